### hw/rtl/lbr_pkg.sv
// Shared constants and types for the LSB-first bit reader.
// Used by lsb_first_bit_reader_unit; no dependencies.
`default_nettype none

package lbr_pkg;

  localparam int STORE_BYTES   = 4096;
  localparam int MAX_READ_BITS = 64;

  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int LEN_W   = 13;    // stream_length_bytes register
  localparam int POS_W   = 16;    // bit position
  localparam int CNT_W   = 7;     // bit_count field
  localparam int BADDR_W = POS_W - 3 + 1;  // byte index, may run past the end
  localparam int NBYTE_W = $clog2(MAX_READ_BITS / 8 + 1);

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_PEEK = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

endpackage

`default_nettype wire

### hw/rtl/lbr_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none

module lbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/lsb_first_bit_reader_unit.sv
// LSB-first bit reader over a loaded byte store: top level.
// Depends on lbr_pkg and lbr_ram.
//
// Input words (s_*) carry a mode in s_tuser: load writes one byte into the
// store, peek/read extract bit_count bits (1..64, larger saturates) LSB-first
// from the current bit position. Each request returns ceil(n/8) bytes on m_*,
// m_tlast on the final byte, m_tuser set on every byte when any requested bit
// lies at or past the configured stream length (those bits read as zero).
// A read advances the position by n bits; a peek leaves it.
// A load leaves the block idle; a request holds it busy from accept through
// the priming read of the first byte and then one output byte per cycle
// while the receiver takes them, set by the single read port of the byte store,
// which streams one byte per cycle and keeps the previous one for the shift.
// The first byte reaches m_* through the prime and generate states into the output register.
// When the receiver stalls, the byte generator waits and re-reads the same
// memory address; the output register holds its word. A new word is taken
// while the last result byte still waits on the output.
// Reset clears the bit position, the length register and the output valid;
// store contents stay undefined until loaded. No clearing pass.
`default_nettype none

module lsb_first_bit_reader_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: stream_length_bytes
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // byte_addr[11:0], byte_value[19:12], bit_count[26:20]
  input  wire logic [1:0]  s_tuser,   // mode[1:0]
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte[7:0]
  output logic             m_tlast,
  output logic             m_tuser    // overrun[0]
);

  typedef enum logic [1:0] {ST_IDLE, ST_PRIME, ST_GEN} state_t;

  state_t                              state;
  logic [lbr_pkg::POS_W-1:0]           position;
  logic [lbr_pkg::LEN_W-1:0]           len_bytes;
  logic [2:0]                          start_shift;
  logic [2:0]                          count_rem;
  logic [lbr_pkg::NBYTE_W-1:0]         nbytes;
  logic [lbr_pkg::NBYTE_W-1:0]         kcnt;
  logic                                over;
  logic [lbr_pkg::BADDR_W-1:0]         rd_addr;
  logic [lbr_pkg::BADDR_W-1:0]         rd_addr_next;
  logic [7:0]                          lo;

  lbr_pkg::mode_t                      in_mode;
  logic [11:0]                         in_addr;
  logic [7:0]                          in_value;
  logic [lbr_pkg::CNT_W-1:0]           in_count;
  logic [lbr_pkg::CNT_W-1:0]           cnt_sat;
  logic                                s_accept;
  logic                                req_go;
  logic                                is_read;
  logic [lbr_pkg::LEN_W-1:0]           eff_len;
  logic [lbr_pkg::POS_W-1:0]           limit_bits;
  logic [lbr_pkg::POS_W:0]             end_bits;
  logic                                over_in;
  logic [7:0]                          nb_sum;
  logic [lbr_pkg::NBYTE_W-1:0]         nbytes_in;
  logic [7:0]                          ram_rdata;
  logic [7:0]                          cur_byte;
  logic                                out_free;
  logic                                is_last;
  logic [15:0]                         word;
  logic [7:0]                          gen_byte;
  logic                                ram_we;

  assign in_mode  = lbr_pkg::mode_t'(s_tuser);
  assign in_addr  = s_tdata[11:0];
  assign in_value = s_tdata[19:12];
  assign in_count = s_tdata[26:20];

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  assign cnt_sat = (in_count > lbr_pkg::CNT_W'(lbr_pkg::MAX_READ_BITS)) ?
                   lbr_pkg::CNT_W'(lbr_pkg::MAX_READ_BITS) : in_count;
  assign is_read = (in_mode == lbr_pkg::MODE_READ);
  assign req_go  = s_accept && (in_mode == lbr_pkg::MODE_PEEK || is_read) && (cnt_sat != '0);

  assign eff_len = (len_bytes > lbr_pkg::LEN_W'(lbr_pkg::STORE_BYTES)) ?
                   lbr_pkg::LEN_W'(lbr_pkg::STORE_BYTES) : len_bytes;
  assign limit_bits = lbr_pkg::POS_W'({eff_len, 3'b000});
  // overrun when the last requested bit index reaches the limit
  assign end_bits = {1'b0, position} + (lbr_pkg::POS_W + 1)'(cnt_sat);
  assign over_in  = end_bits > {1'b0, limit_bits};

  assign nb_sum    = 8'(cnt_sat) + 8'd7;
  assign nbytes_in = lbr_pkg::NBYTE_W'(nb_sum[7:3]);

  // whole store bytes past the stream end read as zero
  assign cur_byte = (rd_addr < lbr_pkg::BADDR_W'(eff_len)) ? ram_rdata : 8'h00;
  assign out_free = !m_tvalid || m_tready;
  assign is_last  = (kcnt == nbytes - lbr_pkg::NBYTE_W'(1));

  always_comb begin
    word     = {cur_byte, lo} >> start_shift;
    gen_byte = word[7:0];
    if (is_last && count_rem != 3'd0) begin
      gen_byte = gen_byte & ((8'h01 << count_rem) - 8'h01);
    end
  end

  always_comb begin
    case (state)
      ST_IDLE:  rd_addr_next = lbr_pkg::BADDR_W'(position[lbr_pkg::POS_W-1:3]);
      ST_PRIME: rd_addr_next = rd_addr + lbr_pkg::BADDR_W'(1);
      ST_GEN:   rd_addr_next = (out_free && !is_last) ? rd_addr + lbr_pkg::BADDR_W'(1)
                                                      : rd_addr;
      default:  rd_addr_next = rd_addr;
    endcase
  end

  assign ram_we = s_accept && (in_mode == lbr_pkg::MODE_LOAD) &&
                  (17'(in_addr) < 17'(lbr_pkg::STORE_BYTES));

  lbr_ram #(
    .WIDTH (8),
    .DEPTH (lbr_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lbr_pkg::ADDR_W'(in_addr)),
    .wdata (in_value),
    .raddr (lbr_pkg::ADDR_W'(rd_addr_next)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      position  <= '0;
      len_bytes <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      rd_addr <= rd_addr_next;
      if (cfg_wr_en) begin
        len_bytes <= cfg_wr_data;
      end
      // while generating, a taken output word is refilled in the same cycle
      if (m_tvalid && m_tready && state != ST_GEN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_go) begin
            start_shift <= position[2:0];
            count_rem   <= cnt_sat[2:0];
            nbytes      <= nbytes_in;
            over        <= over_in;
            kcnt        <= '0;
            state       <= ST_PRIME;
            if (is_read) begin
              position <= position + lbr_pkg::POS_W'(cnt_sat);
            end
          end
        end
        ST_PRIME: begin
          lo    <= cur_byte;
          state <= ST_GEN;
        end
        ST_GEN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= gen_byte;
            m_tlast  <= is_last;
            m_tuser  <= over;
            lo       <= cur_byte;
            kcnt     <= kcnt + lbr_pkg::NBYTE_W'(1);
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // byte counter stays inside the request while generating
  a_kcnt_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_GEN |-> kcnt < nbytes)
    else $error("byte counter past request length");

  // the first memory read is primed in ST_PRIME, followed directly by ST_GEN
  a_prime_once: assert property (@(posedge clk) disable iff (rst)
    req_go |=> state == ST_PRIME ##1 state == ST_GEN)
    else $error("request did not enter generation after one prime cycle");

  // position moves only on an accepted read
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !(s_accept && is_read) |=> $stable(position))
    else $error("bit position changed without a read");

endmodule

`default_nettype wire

### dv/tb_lsb_first_bit_reader_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for lsb_first_bit_reader_unit: a directed table, then random
// load/peek/read traffic, results checked against a bit-level predictor or hand-typed rows.
// Depends on lbr_pkg and the unit RTL.

module tb_lsb_first_bit_reader_unit;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int IDLE_PCT     = 27;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    lbr_pkg::mode_t md;
    logic [12:0]    arg;     // length for a cfg row, byte_addr for a word row
    logic [7:0]     val;
    logic [6:0]     cnt;
    logic           typed;   // result below is written out by hand
    logic [3:0]     nb;
    logic [63:0]    data;
    logic           over;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       over;
  } out_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [12:0] cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // byte_addr[11:0], byte_value[19:12], bit_count[26:20]
  logic [1:0]  s_tuser = '0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // out_byte[7:0]
  logic        m_tlast;
  logic        m_tuser;        // overrun[0]

  // predictor state
  logic [7:0]  store_mem [lbr_pkg::STORE_BYTES];
  bit          written [lbr_pkg::STORE_BYTES];
  logic [15:0] bit_pos = '0;
  logic [12:0] stream_len = '0;
  out_word_t   byte_q [$];

  int errors = 0;
  int words_sent = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit no_gaps = 1'b0;
  bit hold_armed = 1'b0;

  lsb_first_bit_reader_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Extract bits LSB-first from the current position; loads update the store.
  task automatic predict_word(input lbr_pkg::mode_t md, input logic [11:0] addr,
                              input logic [7:0] val, input logic [6:0] cnt,
                              output logic [63:0] bits, output int nb, output bit ovr);
    int n, lim, idx;
    bits = '0;
    nb = 0;
    ovr = 1'b0;
    n = (cnt > lbr_pkg::MAX_READ_BITS) ? lbr_pkg::MAX_READ_BITS : int'(cnt);
    lim = ((stream_len > lbr_pkg::STORE_BYTES) ? lbr_pkg::STORE_BYTES
                                                : int'(stream_len)) * 8;
    case (md)
      lbr_pkg::MODE_LOAD: begin
        store_mem[addr] = val;
        written[addr] = 1'b1;
      end
      lbr_pkg::MODE_PEEK, lbr_pkg::MODE_READ: begin
        if (n != 0) begin
          nb = (n + 7) / 8;
          // indices inside one request run straight past the end, no wrap
          for (int j = 0; j < n; j++) begin
            idx = int'(bit_pos) + j;
            if (idx < lim) bits[j] = store_mem[idx >> 3][idx & 7];
            else ovr = 1'b1;
          end
          if (md == lbr_pkg::MODE_READ) bit_pos = bit_pos + 16'(n);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one word, wait for the handshake, then queue what it must produce.
  task automatic send_word(input lbr_pkg::mode_t md, input logic [11:0] addr,
                           input logic [7:0] val, input logic [6:0] cnt,
                           input bit typed = 1'b0, input int t_nb = 0,
                           input logic [63:0] t_data = '0, input bit t_over = 1'b0);
    logic [63:0] bits;
    int nb;
    bit ovr;
    out_word_t w;
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= md;
    s_tdata  <= {5'b0, cnt, val, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_word(md, addr, val, cnt, bits, nb, ovr);
    if (typed) begin
      bits = t_data;
      nb = t_nb;
      ovr = t_over;
    end
    for (int k = 0; k < nb; k++) begin
      w.data = bits[8*k +: 8];
      w.last = (k == nb - 1);
      w.over = ovr;
      byte_q.push_back(w);
    end
    words_sent++;
    @(negedge clk);
  endtask

  // Length register only changes with the block idle; loads give no result,
  // so a few extra cycles cover one still in flight.
  task automatic set_stream_length(input logic [12:0] len);
    s_tvalid <= 1'b0;
    while (byte_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    stream_len = len;
  endtask

  // Load every in-range byte the request touches that was never written, then send it.
  task automatic issue_request(input lbr_pkg::mode_t md, input logic [6:0] cnt);
    int n, lim_bytes, b_first, b_last;
    n = (cnt > lbr_pkg::MAX_READ_BITS) ? lbr_pkg::MAX_READ_BITS : int'(cnt);
    if (n != 0) begin
      lim_bytes = (stream_len > lbr_pkg::STORE_BYTES) ? lbr_pkg::STORE_BYTES
                                                       : int'(stream_len);
      b_first = int'(bit_pos) >> 3;
      b_last  = (int'(bit_pos) + n - 1) >> 3;
      for (int b = b_first; b <= b_last && b < lim_bytes; b++)
        if (!written[b])
          send_word(lbr_pkg::MODE_LOAD, 12'(b), 8'($urandom), 7'($urandom));
    end
    send_word(md, 12'($urandom), 8'($urandom), cnt);
  endtask

  function automatic lbr_pkg::mode_t any_request();
    return ($urandom_range(1) != 0) ? lbr_pkg::MODE_READ : lbr_pkg::MODE_PEEK;
  endfunction

  function automatic logic [6:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 7'($urandom_range(1, 64));
    if (r < 85) return 7'($urandom_range(65, 127));  // saturates
    return 7'(8 * $urandom_range(1, 8));
  endfunction

  task automatic random_traffic(input int target);
    int goal, pick, nload, nreq;
    goal = words_sent + target;
    while (words_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // loads around the current position, then requests over them
        nload = $urandom_range(1, 4);
        for (int k = 0; k < nload; k++)
          send_word(lbr_pkg::MODE_LOAD, 12'((int'(bit_pos) >> 3) + k), 8'($urandom),
                    7'($urandom));
        nreq = $urandom_range(1, 3);
        for (int k = 0; k < nreq; k++) issue_request(any_request(), rand_count());
      end else if (pick < 75) begin
        issue_request(any_request(), rand_count());
      end else if (pick < 85) begin
        send_word(lbr_pkg::MODE_LOAD, 12'($urandom), 8'($urandom), 7'($urandom));
      end else if (pick < 93) begin
        send_word(lbr_pkg::MODE_NONE, 12'($urandom), 8'($urandom), 7'($urandom));
      end else begin
        send_word(any_request(), 12'($urandom), 8'($urandom), 7'd0);
      end
    end
  endtask

  function automatic stim_row_t cfg_row(input logic [12:0] len);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.arg = len;
    return r;
  endfunction

  function automatic stim_row_t word_row(input lbr_pkg::mode_t md, input logic [11:0] addr,
                                         input logic [7:0] val, input logic [6:0] cnt,
                                         input logic typed, input logic [3:0] nb,
                                         input logic [63:0] data, input logic over);
    stim_row_t r;
    r.kind = ROW_WORD;
    r.md = md;
    r.arg = {1'b0, addr};
    r.val = val;
    r.cnt = cnt;
    r.typed = typed;
    r.nb = nb;
    r.data = data;
    r.over = over;
    return r;
  endfunction

  // receiver: random stalls, or a long counted hold-off when armed
  always @(negedge clk) begin
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    out_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (byte_q.size() == 0) begin
        report_mismatch($sformatf("word %02h with nothing expected", m_tdata));
      end else begin
        w = byte_q.pop_front();
        if (m_tdata !== w.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, w.data));
        if (m_tlast !== w.last)
          report_mismatch($sformatf("last %b, want %b", m_tlast, w.last));
        if (m_tuser !== w.over)
          report_mismatch($sformatf("overrun %b, want %b", m_tuser, w.over));
      end
    end
  end

  initial begin
    stim_row_t rows [21];
    rows = '{
      cfg_row(13'd0),
      // nothing loaded, zero length: every bit is past the end
      word_row(lbr_pkg::MODE_PEEK, 12'h000, 8'h00, 7'd1,   1'b1, 4'd1, 64'h0, 1'b1),
      word_row(lbr_pkg::MODE_PEEK, 12'h000, 8'h00, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_NONE, 12'hfff, 8'hff, 7'd64,  1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_LOAD, 12'h000, 8'ha5, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_LOAD, 12'h001, 8'h3c, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_LOAD, 12'h002, 8'hff, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_LOAD, 12'h003, 8'h00, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_LOAD, 12'h004, 8'h81, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_LOAD, 12'h005, 8'h7e, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_LOAD, 12'h006, 8'h55, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_LOAD, 12'h007, 8'haa, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_LOAD, 12'hfff, 8'hff, 7'h7f,  1'b1, 4'd0, 64'h0, 1'b0),
      cfg_row(13'd8),
      // count above the max saturates: the whole 8-byte stream
      word_row(lbr_pkg::MODE_PEEK, 12'h000, 8'h00, 7'd127, 1'b1, 4'd8,
               64'haa55_7e81_00ff_3ca5, 1'b0),
      word_row(lbr_pkg::MODE_READ, 12'h000, 8'h00, 7'd3,   1'b1, 4'd1, 64'h5, 1'b0),
      // straddles the end of the stream
      word_row(lbr_pkg::MODE_READ, 12'h000, 8'h00, 7'd64,  1'b0, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_READ, 12'h000, 8'h00, 7'd0,   1'b1, 4'd0, 64'h0, 1'b0),
      word_row(lbr_pkg::MODE_READ, 12'h000, 8'h00, 7'd61,  1'b1, 4'd8, 64'h0, 1'b1),
      cfg_row(13'd0),
      word_row(lbr_pkg::MODE_READ, 12'h000, 8'h00, 7'd9,   1'b1, 4'd2, 64'h0, 1'b1)
    };

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG)
        set_stream_length(rows[i].arg);
      else
        send_word(rows[i].md, rows[i].arg[11:0], rows[i].val, rows[i].cnt,
                  rows[i].typed, int'(rows[i].nb), rows[i].data, rows[i].over);
    end

    set_stream_length(13'd40);
    random_traffic(70);
    set_stream_length(13'h1fff);
    random_traffic(130);

    // no idling on either side; receiver holds off so the input backs up
    set_stream_length(13'd4096);
    no_gaps = 1'b1;
    hold_armed = 1'b1;
    random_traffic(130);
    no_gaps = 1'b0;

    set_stream_length(13'($urandom_range(1, 600)));
    random_traffic(100);
    set_stream_length(13'd1);
    random_traffic(30);

    s_tvalid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
